/* rtl/core/suv_pkg.sv */
// ----------------------------------------------------------------------------
// suv_pkg: shared constants for the sphere uv mapping block
// default widths, fixed-point guard bits, cordic gain and arctangent table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package suv_pkg;

  // defaults for the top-level parameters
  localparam int COORD_WIDTH_DEF   = 16;
  localparam int UV_WIDTH_DEF      = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  // fraction bits added below the coordinates in the cordic datapath
  localparam int GUARD_BITS = 20;

  // entries in the arctangent table, also the upper bound on stages
  localparam int TABLE_LEN = 24;

  // angle accumulator width, units of 2^-32 turn
  localparam int ANGLE_W = 32;

  // inverse cordic gain, q30, rounded to nearest
  localparam int KINV_W = 30;
  localparam logic [KINV_W-1:0] KINV_Q30 = 30'd652032874;

  // atan(2^-i) / (2 pi) * 2^32, rounded to nearest
  function automatic logic [ANGLE_W-1:0] atan_turn(input int idx);
    logic [ANGLE_W-1:0] val;
    unique case (idx)
      0:       val = 32'd536870912;
      1:       val = 32'd316933406;
      2:       val = 32'd167458907;
      3:       val = 32'd85004756;
      4:       val = 32'd42667331;
      5:       val = 32'd21354465;
      6:       val = 32'd10679838;
      7:       val = 32'd5340245;
      8:       val = 32'd2670163;
      9:       val = 32'd1335087;
      10:      val = 32'd667544;
      11:      val = 32'd333772;
      12:      val = 32'd166886;
      13:      val = 32'd83443;
      14:      val = 32'd41722;
      15:      val = 32'd20861;
      16:      val = 32'd10430;
      17:      val = 32'd5215;
      18:      val = 32'd2608;
      19:      val = 32'd1304;
      20:      val = 32'd652;
      21:      val = 32'd326;
      22:      val = 32'd163;
      23:      val = 32'd81;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/sphere_uv_mapping.sv */
// ----------------------------------------------------------------------------
// sphere_uv_mapping: vertex position to spherical texture coordinates
// u = frac(1 - atan2(-x, z) / 2pi), v = |0.5 - atan(y / r) / pi| saturated,
// angles from two pipelined cordic vectoring passes
// ----------------------------------------------------------------------------
// channel   dir  handshake                  payload
// s_axis    in   s_axis_tvalid/tready       tdata: pos_x, pos_y, pos_z
// m_axis    out  m_axis_tvalid/tready       tdata: tex_u, tex_v
//
// one request per cycle sustained while m_axis_tready stays high; N = min(CORDIC_STAGES, 24)
// the two cordic passes of N iterations each set the depth of the pipeline
// every stage has its own valid bit and loads whenever it is empty or its
// successor moves, so bubbles close up and input is taken while a result waits
// reset clears only the valid bits, payload registers are not reset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sphere_uv_mapping #(
  parameter int COORD_WIDTH   = suv_pkg::COORD_WIDTH_DEF,
  parameter int UV_WIDTH      = suv_pkg::UV_WIDTH_DEF,
  parameter int CORDIC_STAGES = suv_pkg::CORDIC_STAGES_DEF,
  localparam int IN_TDATA_W   = ((3 * COORD_WIDTH + 7) / 8) * 8,
  localparam int OUT_TDATA_W  = ((2 * UV_WIDTH + 7) / 8) * 8
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  // vertex request
  input  wire                    s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire  [IN_TDATA_W-1:0]  s_axis_tdata,   // pos_x, pos_y, pos_z, zero pad
  // texture coordinate result
  output logic                   m_axis_tvalid,
  input  wire                    m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // tex_u, tex_v, zero pad
);

  localparam int CW  = COORD_WIDTH;
  localparam int GB  = suv_pkg::GUARD_BITS;
  localparam int AW  = suv_pkg::ANGLE_W;
  localparam int KW  = suv_pkg::KINV_W;
  // cordic datapath: coordinate, guard bits, gain growth and sign
  localparam int DW  = CW + GB + 3;
  // unsigned radius width for the gain multiply, at least one bit above the low word
  localparam int XW  = (DW > 33) ? DW - 1 : 33;
  localparam int HW  = XW - 32;
  localparam int SH  = AW - UV_WIDTH;
  localparam int S1W = CW + 2;
  localparam int S2W = CW + 1 + AW;
  localparam int VW  = 35;

  localparam logic [AW:0]   HALF_U = (AW + 1)'(1) << (SH - 1);
  localparam logic [VW-1:0] HALF_V = VW'(1) << (SH - 1);
  localparam logic [62:0]   RND_K  = 63'd1 << (KW - 1);

  // --------------------------------------------------------------------------
  // ready chain, back to front
  // --------------------------------------------------------------------------
  logic vld_p_q, vld_m1_q, vld_m2_q, vld_f1_q, vld_f2_q;
  logic rdy_p, rdy_m1, rdy_m2, rdy_f1, rdy_f2;
  logic c1_in_ready, c1_out_valid;
  logic c2_in_ready, c2_out_valid;

  assign rdy_f2 = ~vld_f2_q | m_axis_tready;
  assign rdy_f1 = ~vld_f1_q | rdy_f2;
  assign rdy_m2 = ~vld_m2_q | c2_in_ready;
  assign rdy_m1 = ~vld_m1_q | rdy_m2;
  assign rdy_p  = ~vld_p_q  | c1_in_ready;

  assign s_axis_tready = rdy_p;

  // --------------------------------------------------------------------------
  // prep stage: scale into the guard bits, fold z < 0 into a half-turn offset
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] pos_x, pos_y, pos_z;
  logic signed [DW-1:0] xw, zw;
  logic signed [DW-1:0] cx_p_d, cy_p_d;
  logic                 deg_p_d;

  assign pos_x = s_axis_tdata[CW-1:0];
  assign pos_y = s_axis_tdata[2*CW-1:CW];
  assign pos_z = s_axis_tdata[3*CW-1:2*CW];

  assign xw = DW'(pos_x) <<< GB;
  assign zw = DW'(pos_z) <<< GB;

  always_comb begin
    deg_p_d = (pos_x == '0) && (pos_z == '0);
    if (pos_z[CW-1]) begin
      // rotate by half a turn: (z, -x) becomes (-z, x)
      cx_p_d = -zw;
      cy_p_d = xw;
    end else begin
      cx_p_d = zw;
      cy_p_d = -xw;
    end
  end

  logic signed [DW-1:0] cx_p_q, cy_p_q;
  logic [S1W-1:0]       side1_p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_p_q <= 1'b0;
    end else if (rdy_p) begin
      vld_p_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_p && s_axis_tvalid) begin
      cx_p_q    <= cx_p_d;
      cy_p_q    <= cy_p_d;
      side1_p_q <= {deg_p_d, pos_z[CW-1], pos_y};
    end
  end

  // --------------------------------------------------------------------------
  // longitude pass on (z, -x)
  // --------------------------------------------------------------------------
  logic signed [DW-1:0] c1_x;
  logic [AW-1:0]        c1_angle;
  logic [S1W-1:0]       c1_side;

  suv_cordic #(
    .DW     (DW),
    .STAGES (CORDIC_STAGES),
    .SIDE_W (S1W)
  ) u_cordic_lon (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vld_p_q),
    .in_ready_o  (c1_in_ready),
    .in_x_i      (cx_p_q),
    .in_y_i      (cy_p_q),
    .in_side_i   (side1_p_q),
    .out_valid_o (c1_out_valid),
    .out_ready_i (rdy_m1),
    .out_x_o     (c1_x),
    .out_angle_o (c1_angle),
    .out_side_o  (c1_side)
  );

  // --------------------------------------------------------------------------
  // gain removal, first half: two partial products of radius times kinv
  // --------------------------------------------------------------------------
  logic [XW-1:0]      ux;
  logic [61:0]        p_lo_d;
  logic [HW+KW-1:0]   p_hi_d;
  logic [AW-1:0]      lon_m1_d;

  assign ux       = XW'(c1_x[DW-2:0]);
  assign p_lo_d   = {30'd0, ux[31:0]} * {32'd0, suv_pkg::KINV_Q30};
  assign p_hi_d   = (HW + KW)'(ux[XW-1:32]) * (HW + KW)'(suv_pkg::KINV_Q30);
  assign lon_m1_d = {c1_side[CW], {(AW-1){1'b0}}} + c1_angle;

  logic [61:0]      p_lo_q;
  logic [HW+KW-1:0] p_hi_q;
  logic [AW-1:0]    lon_m1_q;
  logic             deg_m1_q;
  logic [CW-1:0]    y_m1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_m1_q <= 1'b0;
    end else if (rdy_m1) begin
      vld_m1_q <= c1_out_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_m1 && c1_out_valid) begin
      p_lo_q   <= p_lo_d;
      p_hi_q   <= p_hi_d;
      lon_m1_q <= lon_m1_d;
      deg_m1_q <= c1_side[CW+1];
      y_m1_q   <= c1_side[CW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // gain removal, second half: sum with round to nearest at q30
  // --------------------------------------------------------------------------
  logic [62:0]          lo_rnd;
  logic [XW:0]          rad;
  logic signed [DW-1:0] rx_m2_d, ry_m2_d;

  assign lo_rnd  = {1'b0, p_lo_q} + RND_K;
  assign rad     = {1'b0, p_hi_q, 2'b00} + (XW + 1)'(lo_rnd[62:KW]);
  assign rx_m2_d = {1'b0, rad[DW-2:0]};
  assign ry_m2_d = DW'($signed(y_m1_q)) <<< GB;

  logic signed [DW-1:0] rx_m2_q, ry_m2_q;
  logic [S2W-1:0]       side2_m2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_m2_q <= 1'b0;
    end else if (rdy_m2) begin
      vld_m2_q <= vld_m1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_m2 && vld_m1_q) begin
      rx_m2_q    <= rx_m2_d;
      ry_m2_q    <= ry_m2_d;
      side2_m2_q <= {deg_m1_q, y_m1_q, lon_m1_q};
    end
  end

  // --------------------------------------------------------------------------
  // latitude pass on (radius, y)
  // --------------------------------------------------------------------------
  logic [AW-1:0]  c2_angle;
  logic [S2W-1:0] c2_side;

  suv_cordic #(
    .DW     (DW),
    .STAGES (CORDIC_STAGES),
    .SIDE_W (S2W)
  ) u_cordic_lat (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vld_m2_q),
    .in_ready_o  (c2_in_ready),
    .in_x_i      (rx_m2_q),
    .in_y_i      (ry_m2_q),
    .in_side_i   (side2_m2_q),
    .out_valid_o (c2_out_valid),
    .out_ready_i (rdy_f1),
    .out_x_o     (),
    .out_angle_o (c2_angle),
    .out_side_o  (c2_side)
  );

  // --------------------------------------------------------------------------
  // first output stage: poles on the y axis, u rounding, v before folding
  // --------------------------------------------------------------------------
  logic                 deg_f1;
  logic [CW-1:0]        y_f1;
  logic [AW-1:0]        lon_f1, lat_f1, u32;
  logic [AW:0]          u_sum;
  logic signed [VW-1:0] lat_ext, vv_f1_d;

  assign deg_f1 = c2_side[S2W-1];
  assign y_f1   = c2_side[AW+CW-1:AW];

  always_comb begin
    lon_f1 = c2_side[AW-1:0];
    lat_f1 = c2_angle;
    if (deg_f1) begin
      // straight up or down the y axis, or the origin
      lon_f1 = '0;
      if (y_f1[CW-1]) begin
        lat_f1 = -(AW'(1) << (AW - 2));
      end else if (y_f1 != '0) begin
        lat_f1 = AW'(1) << (AW - 2);
      end else begin
        lat_f1 = '0;
      end
    end
  end

  assign u32     = -lon_f1;
  assign u_sum   = {1'b0, u32} + HALF_U;
  assign lat_ext = VW'($signed(lat_f1));
  assign vv_f1_d = (VW'(1) <<< (AW - 1)) - (lat_ext <<< 1);

  logic [UV_WIDTH-1:0]  uq_f1_q;
  logic signed [VW-1:0] vv_f1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_f1_q <= 1'b0;
    end else if (rdy_f1) begin
      vld_f1_q <= c2_out_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_f1 && c2_out_valid) begin
      uq_f1_q <= u_sum[AW-1:SH];   // wraps modulo one turn
      vv_f1_q <= vv_f1_d;
    end
  end

  // --------------------------------------------------------------------------
  // output register: fold past the pole, round, saturate v
  // --------------------------------------------------------------------------
  logic [VW-1:0]       v_sum;
  logic [UV_WIDTH-1:0] vq_f2_d;

  // |vv| + half in one add
  assign v_sum   = vv_f1_q[VW-1] ? (HALF_V - VW'(vv_f1_q)) : (VW'(vv_f1_q) + HALF_V);
  assign vq_f2_d = (|v_sum[VW-1:AW]) ? {UV_WIDTH{1'b1}} : v_sum[AW-1:SH];

  logic [UV_WIDTH-1:0] uq_f2_q, vq_f2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_f2_q <= 1'b0;
    end else if (rdy_f2) begin
      vld_f2_q <= vld_f1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_f2 && vld_f1_q) begin
      uq_f2_q <= uq_f1_q;
      vq_f2_q <= vq_f2_d;
    end
  end

  assign m_axis_tvalid = vld_f2_q;
  assign m_axis_tdata  = OUT_TDATA_W'({vq_f2_q, uq_f2_q});

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  // an accepted request lands in the prep stage
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> vld_p_q)
    else $error("accepted request missing from prep stage");

  // the longitude pass keeps the radius non-negative
  a_radius_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c1_out_valid |-> !c1_x[DW-1])
    else $error("negative radius out of longitude pass");

  // a stalled first output stage keeps its contents
  a_f1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_f1_q && !rdy_f2) |=> (vld_f1_q && $stable(uq_f1_q) && $stable(vv_f1_q)))
    else $error("first output stage lost data under stall");

  // a full gain stage that cannot drain blocks the one before it
  a_m1_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_m1_q && !rdy_m2) |-> !rdy_m1)
    else $error("gain stage overwritten while stalled");

endmodule

`default_nettype wire

/* rtl/core/suv_cordic.sv */
// ----------------------------------------------------------------------------
// suv_cordic: pipelined cordic vectoring pass
// one iteration per register stage, drives y to zero and sums the angle,
// a side word travels along with each request
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module suv_cordic #(
  parameter int DW     = 39,
  parameter int STAGES = suv_pkg::CORDIC_STAGES_DEF,
  parameter int SIDE_W = 1
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  wire  signed [DW-1:0]              in_x_i,
  input  wire  signed [DW-1:0]              in_y_i,
  input  wire         [SIDE_W-1:0]          in_side_i,
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output logic signed [DW-1:0]              out_x_o,
  output logic        [suv_pkg::ANGLE_W-1:0] out_angle_o,
  output logic        [SIDE_W-1:0]          out_side_o
);

  localparam int N = (STAGES > suv_pkg::TABLE_LEN) ? suv_pkg::TABLE_LEN : STAGES;

  logic signed [DW-1:0]               x_q     [N];
  logic signed [DW-1:0]               y_q     [N];
  logic        [suv_pkg::ANGLE_W-1:0] angle_q [N];
  logic        [SIDE_W-1:0]           side_q  [N];
  logic        [N-1:0]                vld_q;
  logic        [N:0]                  rdy;

  assign rdy[N] = out_ready_i;

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [DW-1:0]               x_in;
    logic signed [DW-1:0]               y_in;
    logic        [suv_pkg::ANGLE_W-1:0] angle_in;
    logic        [SIDE_W-1:0]           side_in;
    logic                               vld_in;
    logic signed [DW-1:0]               x_d;
    logic signed [DW-1:0]               y_d;
    logic        [suv_pkg::ANGLE_W-1:0] angle_d;
    logic                               rot_pos;

    if (i == 0) begin : g_first
      assign x_in     = in_x_i;
      assign y_in     = in_y_i;
      assign angle_in = '0;
      assign side_in  = in_side_i;
      assign vld_in   = in_valid_i;
    end else begin : g_next
      assign x_in     = x_q[i-1];
      assign y_in     = y_q[i-1];
      assign angle_in = angle_q[i-1];
      assign side_in  = side_q[i-1];
      assign vld_in   = vld_q[i-1];
    end

    // zero residual rotates as positive
    assign rot_pos = ~y_in[DW-1];

    always_comb begin
      if (rot_pos) begin
        x_d     = x_in + (y_in >>> i);
        y_d     = y_in - (x_in >>> i);
        angle_d = angle_in + suv_pkg::atan_turn(i);
      end else begin
        x_d     = x_in - (y_in >>> i);
        y_d     = y_in + (x_in >>> i);
        angle_d = angle_in - suv_pkg::atan_turn(i);
      end
    end

    assign rdy[i] = ~vld_q[i] | rdy[i+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (rdy[i]) begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[i] && vld_in) begin
        x_q[i]     <= x_d;
        y_q[i]     <= y_d;
        angle_q[i] <= angle_d;
        side_q[i]  <= side_in;
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[N-1];
  assign out_x_o     = x_q[N-1];
  assign out_angle_o = angle_q[N-1];
  assign out_side_o  = side_q[N-1];

endmodule

`default_nettype wire
